// File: design/fve_pkg.sv
`default_nettype none

package fve_pkg;

    localparam int COORD_W = 32;
    localparam int TIME_W  = 48;
    localparam int SPEED_W = 48;
    localparam int THR_W   = 31;
    localparam int FRAC_SHIFT = 16;
    localparam int DIV_STEPS  = SPEED_W;
    localparam int DIV_CNT_W  = 6;

    localparam int S_TDATA_W = 176;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 200;

    // event kinds
    localparam logic [1:0] FUNC_DOWN = 2'd0;
    localparam logic [1:0] FUNC_HOLD = 2'd1;
    localparam logic [1:0] FUNC_FREE = 2'd2;
    localparam logic [1:0] FUNC_STOP = 2'd3;

    // register indexes
    localparam logic REG_MOVE_THRESHOLD  = 1'b0;
    localparam logic REG_HOLD_TIME_LIMIT = 1'b1;

    localparam logic [THR_W-1:0]  MOVE_THRESHOLD_RST  = 31'd786432;
    localparam logic [TIME_W-1:0] HOLD_TIME_LIMIT_RST = 48'd100000;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 48'h8000_0000_0000;

    // lane order of the speed store
    localparam logic [1:0] LANE_X   = 2'd0;
    localparam logic [1:0] LANE_Y   = 2'd1;
    localparam logic [1:0] LANE_LON = 2'd2;
    localparam logic [1:0] LANE_LAT = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_LOAD  = 6'b000100,
        S_DIV   = 6'b001000,
        S_STORE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// File: design/fling_velocity_estimator.sv
`default_nettype none

// Fling velocity estimator for kinetic scrolling. One pointer event per slave transaction
// (tuser = event kind: down, hold, free, stop); each event yields exactly one master
// transaction carrying the four stored speeds and the status flags. Down, hold, stop and a
// free cancelled by the rest test pass through the evaluate and done states; the result is
// registered on leaving done. A free with zero elapsed time writes the saturated value in
// one load step per speed lane. A free that computes speeds uses one 48-step restoring
// divider, shared by the four speed lanes in turn (a load, 48 steps and a store per lane,
// between evaluate and done). A new result waits in done while an older one still waits on
// the master side. The block takes one event at a time. It is ready again as soon as the
// result is registered, so it accepts the next event while that result still waits on the
// master side. Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while no event is in flight, which the block itself does not enforce.
module fling_velocity_estimator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // center_x, center_y, center_lon, center_lat, event_time
    input  wire logic [fve_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  wire logic [fve_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // speed_x, speed_y, speed_lon, speed_lat, scroll_active, was_active,
    // zero_interval, 5 zero bits
    output logic [fve_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_addr,
    input  wire logic [fve_pkg::TIME_W-1:0]     cfg_wdata
);

    localparam int CW = fve_pkg::COORD_W;
    localparam int TW = fve_pkg::TIME_W;
    localparam int SW = fve_pkg::SPEED_W;

    fve_pkg::state_t state_reg, state_next;

    logic [fve_pkg::THR_W-1:0] move_threshold_reg, move_threshold_next;
    logic [TW-1:0]             hold_time_limit_reg, hold_time_limit_next;

    // captured event
    logic [1:0]    func_reg, func_next;
    logic [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [CW-1:0] clon_reg, clon_next, clat_reg, clat_next;
    logic [TW-1:0] now_reg, now_next;

    // gesture marks
    logic [CW-1:0] down_x_reg, down_x_next, down_y_reg, down_y_next;
    logic [CW-1:0] down_lon_reg, down_lon_next, down_lat_reg, down_lat_next;
    logic [TW-1:0] down_stamp_reg, down_stamp_next;
    logic [CW-1:0] hold_x_reg, hold_x_next, hold_y_reg, hold_y_next;
    logic [TW-1:0] hold_stamp_reg, hold_stamp_next;
    logic [SW-1:0] speed_reg [4];
    logic [SW-1:0] speed_next [4];
    logic          active_reg, active_next;
    logic          was_reg, was_next;
    logic          zero_reg, zero_next;

    // shared divider
    logic [1:0]                    lane_reg, lane_next;
    logic [fve_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TW:0]                   den_reg, den_next;
    logic [TW:0]                   rem_reg, rem_next;
    logic [SW-1:0]                 quo_reg, quo_next;
    logic                          dt_neg_reg, dt_neg_next;
    logic                          neg_reg, neg_next;

    logic [fve_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                          out_valid_reg, out_valid_next;

    logic          s_fire;
    logic [TW:0]   hdt, dt, dt_mag;
    logic [CW:0]   dxh, dyh, dxh_mag, dyh_mag;
    logic          rested;
    logic [CW-1:0] cur_sel, down_sel;
    logic [CW:0]   delta, delta_mag;
    logic [TW+2:0] trial;

    assign s_axis_tready = (state_reg == fve_pkg::S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;

    // rest test and elapsed time
    always_comb
    begin
        hdt     = {1'b0, now_reg} - {1'b0, hold_stamp_reg};
        dxh     = {cx_reg[CW-1], cx_reg} - {hold_x_reg[CW-1], hold_x_reg};
        dyh     = {cy_reg[CW-1], cy_reg} - {hold_y_reg[CW-1], hold_y_reg};
        dxh_mag = dxh[CW] ? (~dxh + 1'b1) : dxh;
        dyh_mag = dyh[CW] ? (~dyh + 1'b1) : dyh;
        rested  = ($signed(hdt) > $signed({1'b0, hold_time_limit_reg}))
                  && (dxh_mag < {2'b00, move_threshold_reg})
                  && (dyh_mag < {2'b00, move_threshold_reg});
        dt      = {1'b0, now_reg} - {1'b0, down_stamp_reg};
        dt_mag  = dt[TW] ? (~dt + 1'b1) : dt;
    end

    // lane operand select and delta since down
    always_comb
    begin
        case (lane_reg)
            fve_pkg::LANE_X:
            begin
                cur_sel  = cx_reg;
                down_sel = down_x_reg;
            end
            fve_pkg::LANE_Y:
            begin
                cur_sel  = cy_reg;
                down_sel = down_y_reg;
            end
            fve_pkg::LANE_LON:
            begin
                cur_sel  = clon_reg;
                down_sel = down_lon_reg;
            end
            default:
            begin
                cur_sel  = clat_reg;
                down_sel = down_lat_reg;
            end
        endcase
        delta     = {cur_sel[CW-1], cur_sel} - {down_sel[CW-1], down_sel};
        delta_mag = delta[CW] ? (~delta + 1'b1) : delta;
    end

    // one restoring division step
    assign trial = {1'b0, rem_reg, quo_reg[SW-1]} - {2'b00, den_reg};

    always_comb
    begin
        state_next           = state_reg;
        move_threshold_next  = move_threshold_reg;
        hold_time_limit_next = hold_time_limit_reg;
        func_next            = func_reg;
        cx_next              = cx_reg;
        cy_next              = cy_reg;
        clon_next            = clon_reg;
        clat_next            = clat_reg;
        now_next             = now_reg;
        down_x_next          = down_x_reg;
        down_y_next          = down_y_reg;
        down_lon_next        = down_lon_reg;
        down_lat_next        = down_lat_reg;
        down_stamp_next      = down_stamp_reg;
        hold_x_next          = hold_x_reg;
        hold_y_next          = hold_y_reg;
        hold_stamp_next      = hold_stamp_reg;
        speed_next           = speed_reg;
        active_next          = active_reg;
        was_next             = was_reg;
        zero_next            = zero_reg;
        lane_next            = lane_reg;
        cnt_next             = cnt_reg;
        den_next             = den_reg;
        rem_next             = rem_reg;
        quo_next             = quo_reg;
        dt_neg_next          = dt_neg_reg;
        neg_next             = neg_reg;
        out_data_next        = out_data_reg;
        out_valid_next       = out_valid_reg;

        if (cfg_we)
        begin
            if (cfg_addr == fve_pkg::REG_MOVE_THRESHOLD)
                move_threshold_next = cfg_wdata[fve_pkg::THR_W-1:0];
            else
                hold_time_limit_next = cfg_wdata;
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            fve_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    func_next  = s_axis_tuser;
                    cx_next    = s_axis_tdata[CW-1:0];
                    cy_next    = s_axis_tdata[2*CW-1:CW];
                    clon_next  = s_axis_tdata[3*CW-1:2*CW];
                    clat_next  = s_axis_tdata[4*CW-1:3*CW];
                    now_next   = s_axis_tdata[4*CW+TW-1:4*CW];
                    was_next   = 1'b0;
                    zero_next  = 1'b0;
                    state_next = fve_pkg::S_EVAL;
                end
            end
            fve_pkg::S_EVAL:
            begin
                state_next = fve_pkg::S_DONE;
                case (func_reg)
                    fve_pkg::FUNC_DOWN:
                    begin
                        down_x_next     = cx_reg;
                        down_y_next     = cy_reg;
                        down_lon_next   = clon_reg;
                        down_lat_next   = clat_reg;
                        down_stamp_next = now_reg;
                    end
                    fve_pkg::FUNC_HOLD:
                    begin
                        hold_x_next     = cx_reg;
                        hold_y_next     = cy_reg;
                        hold_stamp_next = now_reg;
                    end
                    fve_pkg::FUNC_FREE:
                    begin
                        if (!rested)
                        begin
                            // divisor is 2*|dt|
                            den_next    = {dt_mag[TW-1:0], 1'b0};
                            dt_neg_next = dt[TW];
                            zero_next   = (dt == '0);
                            active_next = 1'b1;
                            lane_next   = fve_pkg::LANE_X;
                            state_next  = fve_pkg::S_LOAD;
                        end
                    end
                    default:
                    begin
                        was_next    = active_reg;
                        active_next = 1'b0;
                    end
                endcase
            end
            fve_pkg::S_LOAD:
            begin
                if (zero_reg)
                begin
                    if (delta[CW])
                        speed_next[lane_reg] = fve_pkg::SPEED_MIN;
                    else if (delta != '0)
                        speed_next[lane_reg] = fve_pkg::SPEED_MAX;
                    else
                        speed_next[lane_reg] = '0;
                    if (lane_reg == fve_pkg::LANE_LAT)
                        state_next = fve_pkg::S_DONE;
                    else
                        lane_next = lane_reg + 2'd1;
                end
                else
                begin
                    // dividend is |delta| * 2^16, always below 2^48
                    quo_next   = {delta_mag[CW-1:0], {fve_pkg::FRAC_SHIFT{1'b0}}};
                    rem_next   = '0;
                    cnt_next   = '0;
                    neg_next   = delta[CW] ^ dt_neg_reg;
                    state_next = fve_pkg::S_DIV;
                end
            end
            fve_pkg::S_DIV:
            begin
                if (!trial[TW+2])
                begin
                    rem_next = trial[TW:0];
                    quo_next = {quo_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[TW-1:0], quo_reg[SW-1]};
                    quo_next = {quo_reg[SW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == fve_pkg::DIV_CNT_W'(fve_pkg::DIV_STEPS - 1))
                    state_next = fve_pkg::S_STORE;
            end
            fve_pkg::S_STORE:
            begin
                // truncation toward zero: negate the magnitude quotient
                speed_next[lane_reg] = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                if (lane_reg == fve_pkg::LANE_LAT)
                    state_next = fve_pkg::S_DONE;
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = fve_pkg::S_LOAD;
                end
            end
            fve_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {5'b00000, zero_reg, was_reg, active_reg,
                                      speed_reg[3], speed_reg[2], speed_reg[1], speed_reg[0]};
                    out_valid_next = 1'b1;
                    state_next     = fve_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fve_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= fve_pkg::S_IDLE;
            move_threshold_reg  <= fve_pkg::MOVE_THRESHOLD_RST;
            hold_time_limit_reg <= fve_pkg::HOLD_TIME_LIMIT_RST;
            down_x_reg          <= '0;
            down_y_reg          <= '0;
            down_lon_reg        <= '0;
            down_lat_reg        <= '0;
            down_stamp_reg      <= '0;
            hold_x_reg          <= '0;
            hold_y_reg          <= '0;
            hold_stamp_reg      <= '0;
            for (int i = 0; i < 4; i++)
                speed_reg[i] <= '0;
            active_reg          <= 1'b0;
            was_reg             <= 1'b0;
            zero_reg            <= 1'b0;
            lane_reg            <= '0;
            cnt_reg             <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            move_threshold_reg  <= move_threshold_next;
            hold_time_limit_reg <= hold_time_limit_next;
            down_x_reg          <= down_x_next;
            down_y_reg          <= down_y_next;
            down_lon_reg        <= down_lon_next;
            down_lat_reg        <= down_lat_next;
            down_stamp_reg      <= down_stamp_next;
            hold_x_reg          <= hold_x_next;
            hold_y_reg          <= hold_y_next;
            hold_stamp_reg      <= hold_stamp_next;
            speed_reg           <= speed_next;
            active_reg          <= active_next;
            was_reg             <= was_next;
            zero_reg            <= zero_next;
            lane_reg            <= lane_next;
            cnt_reg             <= cnt_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        clon_reg     <= clon_next;
        clat_reg     <= clat_next;
        now_reg      <= now_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dt_neg_reg   <= dt_neg_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fve_pkg::S_DIV) |-> (cnt_reg < fve_pkg::DIV_CNT_W'(fve_pkg::DIV_STEPS)))
        else $error("divider step count out of range");

    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fve_pkg::S_STORE) |-> !quo_reg[SW-1])
        else $error("speed quotient overflows signed range");

    a_active_while_computing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fve_pkg::S_LOAD || state_reg == fve_pkg::S_DIV
         || state_reg == fve_pkg::S_STORE) |-> active_reg)
        else $error("speed computation without active flag");

    a_no_divide_on_zero_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fve_pkg::S_DIV) |-> !zero_reg)
        else $error("divider started with zero elapsed time");

    a_result_only_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == fve_pkg::S_DONE))
        else $error("result presented outside done state");

endmodule

`default_nettype wire

// File: sim/fling_velocity_estimator_tb.sv
module fling_velocity_estimator_tb;

    localparam longint SPD_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SPD_LO = -64'sh0000_8000_0000_0000;
    localparam logic [fve_pkg::COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [fve_pkg::COORD_W-1:0] C_MIN = 32'h8000_0000;
    localparam logic [fve_pkg::TIME_W-1:0] T_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [fve_pkg::THR_W-1:0] THR_MAX = 31'h7FFF_FFFF;
    localparam int PHASE_ITEMS = 140;
    localparam int NUM_PHASES = 8;

    typedef struct packed {
        logic                             zero;
        logic                             was;
        logic                             active;
        logic [3:0][fve_pkg::SPEED_W-1:0] speed;
    } fling_result_t;

    class fling_tracker;
        logic [fve_pkg::THR_W-1:0]  thr;
        logic [fve_pkg::TIME_W-1:0] hold_limit;
        longint            down_x, down_y, down_lon, down_lat, down_t;
        longint            hold_x, hold_y, hold_t;
        longint            speeds [4];
        bit                active;
        fling_result_t     queued_results [$];
        int                errors;

        function new();
            thr = fve_pkg::MOVE_THRESHOLD_RST;
            hold_limit = fve_pkg::HOLD_TIME_LIMIT_RST;
            down_x = 0; down_y = 0; down_lon = 0; down_lat = 0; down_t = 0;
            hold_x = 0; hold_y = 0; hold_t = 0;
            foreach (speeds[i]) speeds[i] = 0;
            active = 0;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [fve_pkg::TIME_W-1:0] v);
            if (idx == fve_pkg::REG_MOVE_THRESHOLD)
                thr = v[fve_pkg::THR_W-1:0];
            else
                hold_limit = v;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint speed_for(longint delta, longint dt);
            longint q;
            if (dt == 0)
                return delta > 0 ? SPD_HI : (delta < 0 ? SPD_LO : 0);
            q = (delta * 65536) / (2 * dt);
            if (q > SPD_HI) q = SPD_HI;
            if (q < SPD_LO) q = SPD_LO;
            return q;
        endfunction

        function void note_event(logic [1:0] f, logic [fve_pkg::COORD_W-1:0] x,
                                 logic [fve_pkg::COORD_W-1:0] y,
                                 logic [fve_pkg::COORD_W-1:0] lon,
                                 logic [fve_pkg::COORD_W-1:0] lat,
                                 logic [fve_pkg::TIME_W-1:0] t);
            longint        cx, cy, clon, clat, now, hdt, dt;
            bit            rested;
            fling_result_t r;
            cx = longint'($signed(x));
            cy = longint'($signed(y));
            clon = longint'($signed(lon));
            clat = longint'($signed(lat));
            now = longint'({16'd0, t});
            r.was = 1'b0;
            r.zero = 1'b0;
            case (f)
                fve_pkg::FUNC_DOWN:
                begin
                    down_x = cx; down_y = cy; down_lon = clon; down_lat = clat;
                    down_t = now;
                end
                fve_pkg::FUNC_HOLD:
                begin
                    hold_x = cx; hold_y = cy; hold_t = now;
                end
                fve_pkg::FUNC_FREE:
                begin
                    hdt = now - hold_t;
                    // a long rest with little movement cancels the fling
                    rested = hdt > longint'({16'd0, hold_limit})
                             && mag(cx - hold_x) < longint'(thr)
                             && mag(cy - hold_y) < longint'(thr);
                    if (!rested)
                    begin
                        dt = now - down_t;
                        speeds[0] = speed_for(cx - down_x, dt);
                        speeds[1] = speed_for(cy - down_y, dt);
                        speeds[2] = speed_for(clon - down_lon, dt);
                        speeds[3] = speed_for(clat - down_lat, dt);
                        r.zero = (dt == 0);
                        active = 1;
                    end
                end
                default:
                begin
                    r.was = active;
                    active = 0;
                end
            endcase
            for (int i = 0; i < 4; i++)
                r.speed[i] = speeds[i][fve_pkg::SPEED_W-1:0];
            r.active = active;
            queued_results.push_back(r);
        endfunction

        function void mismatch(string field, logic [fve_pkg::SPEED_W-1:0] e,
                               logic [fve_pkg::SPEED_W-1:0] a);
            errors++;
            $error("%s: expected %h, got %h", field, e, a);
        endfunction

        function void check_result(logic [fve_pkg::M_TDATA_W-1:0] d);
            fling_result_t e;
            string         lane_names [4];
            lane_names = '{"speed_x", "speed_y", "speed_lon", "speed_lat"};
            if (queued_results.size() == 0)
            begin
                errors++;
                $error("result transaction with no pending event");
                return;
            end
            e = queued_results.pop_front();
            for (int i = 0; i < 4; i++)
                if (d[fve_pkg::SPEED_W*i +: fve_pkg::SPEED_W] !== e.speed[i])
                    mismatch(lane_names[i], e.speed[i],
                             d[fve_pkg::SPEED_W*i +: fve_pkg::SPEED_W]);
            if (d[4*fve_pkg::SPEED_W] !== e.active)
                mismatch("scroll_active", e.active, d[4*fve_pkg::SPEED_W]);
            if (d[4*fve_pkg::SPEED_W+1] !== e.was)
                mismatch("was_active", e.was, d[4*fve_pkg::SPEED_W+1]);
            if (d[4*fve_pkg::SPEED_W+2] !== e.zero)
                mismatch("zero_interval", e.zero, d[4*fve_pkg::SPEED_W+2]);
        endfunction

        function int pending();
            return queued_results.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic [fve_pkg::S_TDATA_W-1:0]     s_axis_tdata = '0;
    logic [fve_pkg::S_TUSER_W-1:0]     s_axis_tuser = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [fve_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic                              cfg_we = 1'b0;
    logic                              cfg_addr = 1'b0;
    logic [fve_pkg::TIME_W-1:0]        cfg_wdata = '0;

    fling_tracker                      trk;
    bit                                steady = 0;
    int                                stall_left = 0;
    int                                items_sent = 0;
    logic [fve_pkg::TIME_W-1:0]        now_us = '0;

    fling_velocity_estimator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (steady || $urandom_range(0, 99) < 70)
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                       : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            trk.check_result(m_axis_tdata);
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [fve_pkg::TIME_W-1:0] later(logic [fve_pkg::TIME_W-1:0] t);
        logic [63:0] w;
        case ($urandom_range(0, 7))
            0: return t;
            1, 2: return t + fve_pkg::TIME_W'($urandom_range(1, 2000));
            3: return t + trk.hold_limit + fve_pkg::TIME_W'($urandom_range(0, 1));
            4: return t + trk.hold_limit + fve_pkg::TIME_W'($urandom_range(2, 50000));
            5: return t + fve_pkg::TIME_W'($urandom_range(1, 1 << 20));
            6: return t - fve_pkg::TIME_W'($urandom_range(1, 1000));
            default:
            begin
                w = {$urandom, $urandom};
                return w[fve_pkg::TIME_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [fve_pkg::COORD_W-1:0] nudge(logic [fve_pkg::COORD_W-1:0] base);
        int d;
        case ($urandom_range(0, 6))
            0: return base;
            1, 2:
            begin
                d = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                return base + d;
            end
            // right on the threshold, or one below it
            3: return base + {1'b0, trk.thr};
            4: return base - {1'b0, trk.thr} + fve_pkg::COORD_W'($urandom_range(0, 1));
            5:
            begin
                d = int'($urandom_range(0, 1 << 26)) - (1 << 25);
                return base + d;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [fve_pkg::COORD_W-1:0] pick_base();
        if ($urandom_range(0, 1) == 1)
            return $urandom;
        return fve_pkg::COORD_W'($urandom_range(0, 1 << 24) - (1 << 23));
    endfunction

    function automatic logic [fve_pkg::TIME_W-1:0] any_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[fve_pkg::TIME_W-1:0];
    endfunction

    task automatic send_event(input logic [1:0] f, input logic [fve_pkg::COORD_W-1:0] x,
                              input logic [fve_pkg::COORD_W-1:0] y,
                              input logic [fve_pkg::COORD_W-1:0] lon,
                              input logic [fve_pkg::COORD_W-1:0] lat,
                              input logic [fve_pkg::TIME_W-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {t, lat, lon, y, x};
        s_axis_tuser <= f;
        do
            @(posedge clk);
        while (!s_axis_tready);
        trk.note_event(f, x, y, lon, lat, t);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (trk.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [fve_pkg::TIME_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        trk.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic reconfigure(input logic [fve_pkg::THR_W-1:0] thr,
                               input logic [fve_pkg::TIME_W-1:0] lim);
        drain();
        repeat (4) @(posedge clk);
        write_reg(fve_pkg::REG_MOVE_THRESHOLD, {17'd0, thr});
        write_reg(fve_pkg::REG_HOLD_TIME_LIMIT, lim);
    endtask

    // down, up to three holds with nudged positions, then a release and often a stop
    task automatic gesture();
        logic [fve_pkg::COORD_W-1:0] x, y, lon, lat;
        logic [fve_pkg::TIME_W-1:0]  t, t_down;
        int                          n;
        x = pick_base();
        y = pick_base();
        lon = pick_base();
        lat = pick_base();
        t = ($urandom_range(0, 15) == 0) ? any_time() : later(now_us);
        t_down = t;
        send_event(fve_pkg::FUNC_DOWN, x, y, lon, lat, t);
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            x = nudge(x);
            y = nudge(y);
            t = later(t);
            send_event(fve_pkg::FUNC_HOLD, x, y, $urandom, $urandom, t);
        end
        x = nudge(x);
        y = nudge(y);
        lon = nudge(lon);
        lat = nudge(lat);
        t = ($urandom_range(0, 11) == 0) ? t_down : later(t);
        send_event(fve_pkg::FUNC_FREE, x, y, lon, lat, t);
        if ($urandom_range(0, 1) == 1)
            send_event(fve_pkg::FUNC_STOP, $urandom, $urandom, $urandom, $urandom, t);
        now_us = t;
    endtask

    task automatic random_phase();
        int start;
        int r;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                gesture();
            else if (r == 7)
                send_event(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                           any_time());
            else if (r == 8)
            begin
                // release twice without a new down
                send_event(fve_pkg::FUNC_FREE, nudge($urandom), $urandom, $urandom, $urandom,
                           later(now_us));
                send_event(fve_pkg::FUNC_FREE, $urandom, $urandom, $urandom, $urandom,
                           later(now_us));
            end
            else
            begin
                send_event(fve_pkg::FUNC_STOP, $urandom, $urandom, $urandom, $urandom, now_us);
                send_event(fve_pkg::FUNC_STOP, $urandom, $urandom, $urandom, $urandom, now_us);
            end
            if ($urandom_range(0, 40) == 0)
                drain();
        end
    endtask

    initial
    begin
        logic [fve_pkg::THR_W-1:0]  thr;
        logic [fve_pkg::TIME_W-1:0] lim;
        trk = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // release straight after reset, zero elapsed time, saturated speeds
        send_event(fve_pkg::FUNC_FREE, C_MAX, C_MIN, 32'd1, C_MIN, 48'd0);
        send_event(fve_pkg::FUNC_STOP, '0, '0, '0, '0, 48'd0);
        send_event(fve_pkg::FUNC_STOP, '0, '0, '0, '0, 48'd0);
        // time running backwards with the widest deltas
        send_event(fve_pkg::FUNC_DOWN, C_MIN, C_MAX, C_MAX, C_MIN, T_MAX);
        send_event(fve_pkg::FUNC_HOLD, C_MIN, C_MAX, '0, '0, T_MAX);
        send_event(fve_pkg::FUNC_FREE, C_MAX, C_MIN, C_MIN, C_MAX, 48'd0);
        // rested drag is cancelled, then the threshold and time limit boundaries
        send_event(fve_pkg::FUNC_DOWN, '0, '0, '0, '0, 48'd1000);
        send_event(fve_pkg::FUNC_HOLD, '0, '0, '0, '0, 48'd2000);
        send_event(fve_pkg::FUNC_FREE, 32'd100, -32'sd100, 32'd5, 32'd5, 48'd102001);
        send_event(fve_pkg::FUNC_FREE, {1'b0, fve_pkg::MOVE_THRESHOLD_RST}, '0, 32'd7,
                   -32'sd7, 48'd102001);
        send_event(fve_pkg::FUNC_FREE, {1'b0, fve_pkg::MOVE_THRESHOLD_RST} - 1, 32'hFFF4_0001,
                   '0, '0, 48'd102000);
        send_event(fve_pkg::FUNC_STOP, '0, '0, '0, '0, 48'd102000);
        send_event(fve_pkg::FUNC_FREE, '0, '0, '0, '0, 48'd1000);
        send_event(fve_pkg::FUNC_STOP, '0, '0, '0, '0, 48'd1000);
        send_event(fve_pkg::FUNC_HOLD, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h5555_5555, 48'hAAAA_AAAA_AAAA);
        send_event(fve_pkg::FUNC_DOWN, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h5555_5555,
                   32'hAAAA_AAAA, 48'h5555_5555_5555);
        send_event(fve_pkg::FUNC_FREE, 32'h5555_5555, 32'h0000_0000, 32'hAAAA_AAAA,
                   32'h5555_5555, T_MAX);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin thr = '0; lim = '0; end
                1: begin thr = THR_MAX; lim = '0; end
                2: begin thr = THR_MAX; lim = T_MAX; end
                3: begin thr = '0; lim = T_MAX; end
                4:
                begin
                    thr = fve_pkg::MOVE_THRESHOLD_RST;
                    lim = fve_pkg::HOLD_TIME_LIMIT_RST;
                end
                default:
                begin
                    thr = fve_pkg::THR_W'($urandom_range(0, 1 << 22));
                    lim = fve_pkg::TIME_W'($urandom_range(0, 1 << 18));
                end
            endcase
            reconfigure(thr, lim);
            steady = (p % 3 == 2);
            random_phase();
        end

        drain();
        repeat (20) @(posedge clk);
        if (trk.errors == 0 && trk.pending() == 0)
            $display("fling_velocity_estimator verification clean");
        else
            $display("fling_velocity_estimator verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("fling_velocity_estimator verification failed");
        $finish;
    end

endmodule

// File: files.f
design/fve_pkg.sv
design/fling_velocity_estimator.sv
sim/fling_velocity_estimator_tb.sv
